[src/software_timer_bank_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the software timer bank
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define STBU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define STBU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STBU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define STBU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/stbu_pkg.sv]
// ----------------------------------------------------------------------------
// Timer bank package
// Field widths, command and register codes, and the stored timer entry.
// ----------------------------------------------------------------------------
package stbu_pkg;

    localparam int CMD_W      = 2;
    localparam int TIDX_W     = 3;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int COUNT_W    = 4;
    localparam int MASK_W     = 8;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TIMERS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MASK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_MASK   = 2'd2;

    localparam logic [MASK_W-1:0] NOTIFY_MASK_RESET = 8'hFF;

    typedef struct packed {
        logic [MS_W-1:0] remaining_ms;
        logic [MS_W-1:0] reload_ms;
    } timer_entry_t;

endpackage

[src/stbu_if.sv]
// ----------------------------------------------------------------------------
// Timer bank channel interfaces
// Valid/ready channels for command items and expiry event items.
// ----------------------------------------------------------------------------
interface stbu_cmd_if;
    import stbu_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TIDX_W-1:0] timer_index;
    logic [MS_W-1:0]   load_ms;
    logic [MS_W-1:0]   elapsed_ms;

    modport source (output valid, command, timer_index, load_ms, elapsed_ms,
                    input ready);
    modport sink   (input valid, command, timer_index, load_ms, elapsed_ms,
                    output ready);
endinterface

interface stbu_evt_if;
    import stbu_pkg::*;

    logic              valid;
    logic              ready;
    logic [TIDX_W-1:0] expired_timer;
    logic              last;

    modport source (output valid, expired_timer, last, input ready);
    modport sink   (input valid, expired_timer, last, output ready);
endinterface

[src/software_timer_bank_unit.sv]
// ----------------------------------------------------------------------------
// Software timer bank unit
// A bank of one-shot or periodic countdown timers driven by tick items.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Carries
// -------  ---------  ------------------------------------------------------
// cmd      in         tick, start or stop item (index, duration, elapsed)
// evt      out        expiry event item: expired timer index, last flag
// cfg_*    in         write-only register port (count, repeat, notify)
//
// A start or stop item is taken only while the bank is idle. A tick item is
// accepted, then walks over the n timers in use with a read-modify-write of
// the timer RAM for each, and ends in a flush step that releases the final
// event, if any. Each event waits in a one-deep pending register until the
// next one is found, so that the final event of a tick can carry the last
// flag; an event stalled at the output holds the walk on a notifying timer.
// Reset clears the active flags and control registers; RAM needs no clearing.
//
`include "software_timer_bank_unit_assert.svh"

module software_timer_bank_unit #(
    parameter int MAX_TIMERS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    stbu_cmd_if.sink                         cmd,
    stbu_evt_if.source                       evt,
    input  logic                             cfg_we,
    input  logic [stbu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [stbu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import stbu_pkg::*;

    // Index width for the RAM and the active flags; counter width must also
    // hold the count of timers itself.
    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // A count above the bank size acts as the bank size.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (32'(v) > MAX_TIMERS)
        begin
            r = CNT_W'(MAX_TIMERS);
        end
        else
        begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      walk_idx_reg, walk_idx_next;
    logic [MS_W-1:0]       elapsed_reg;
    logic [COUNT_W-1:0]    timers_in_use_reg;
    logic [MASK_W-1:0]     repeat_mask_reg;
    logic [MASK_W-1:0]     notify_mask_reg;
    logic [MAX_TIMERS-1:0] active_reg;

    // Pending event waiting for the next one, and the output register.
    logic                  pend_valid_reg;
    logic [TIDX_W-1:0]     pend_idx_reg;
    logic                  out_valid_reg;
    logic [TIDX_W-1:0]     out_idx_reg;
    logic                  out_last_reg;

    logic [CNT_W-1:0]      n_eff;
    logic [CNT_W-1:0]      new_cnt;
    logic [CNT_W-1:0]      walk_inc;
    logic                  walk_end;
    logic                  cmd_fire;
    logic                  start_ok;
    logic                  stop_ok;
    logic                  tick_go;
    logic                  cfg_count_wr;

    logic                  cur_act;
    logic                  cur_fire;
    logic                  cur_low;
    logic                  cur_notify;
    logic                  cur_repeat;
    logic                  out_free;
    logic                  advance;
    logic                  pend_to_out;
    logic                  last_to_out;

    timer_entry_t          rd_entry;
    timer_entry_t          wb_entry;
    logic [$bits(timer_entry_t)-1:0] ram_rd_data;
    logic [$bits(timer_entry_t)-1:0] ram_wr_data;
    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [IDX_W-1:0]      ram_rd_addr;

    assign n_eff        = clamp_count(timers_in_use_reg);
    assign new_cnt      = clamp_count(cfg_data[COUNT_W-1:0]);
    assign cfg_count_wr = cfg_we && (cfg_index == REG_TIMERS_IN_USE);

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign start_ok  = cmd_fire && (cmd.command == CMD_START)
                       && (32'(cmd.timer_index) < 32'(n_eff));
    assign stop_ok   = cmd_fire && (cmd.command == CMD_STOP)
                       && (32'(cmd.timer_index) < 32'(n_eff));
    assign tick_go   = cmd_fire && (cmd.command == CMD_TICK);

    assign walk_inc = walk_idx_reg + CNT_W'(1);
    assign walk_end = (walk_inc == n_eff);

    // Evaluation of the timer under the walk. Repeat and notify bits exist
    // only for the first eight timers.
    assign rd_entry   = timer_entry_t'(ram_rd_data);
    assign cur_act    = active_reg[walk_idx_reg[IDX_W-1:0]];
    assign cur_fire   = cur_act && (rd_entry.remaining_ms <= elapsed_reg);
    assign cur_low    = (32'(walk_idx_reg) < 32'd8);
    assign cur_notify = cur_fire && cur_low && notify_mask_reg[3'(walk_idx_reg)];
    assign cur_repeat = cur_low && repeat_mask_reg[3'(walk_idx_reg)];

    assign out_free = !out_valid_reg || evt.ready;

    always_comb
    begin
        state_next    = state_reg;
        walk_idx_next = walk_idx_reg;
        advance       = 1'b0;
        pend_to_out   = 1'b0;
        last_to_out   = 1'b0;
        ram_rd_addr   = walk_idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                ram_rd_addr   = '0;
                walk_idx_next = '0;
                if (tick_go)
                begin
                    state_next = (n_eff == '0) ? ST_FLUSH : ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // A new event displaces the pending one into the output
                // register, which must then be free.
                advance     = !(cur_notify && pend_valid_reg && !out_free);
                pend_to_out = advance && cur_notify && pend_valid_reg;
                if (advance)
                begin
                    if (walk_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        walk_idx_next = walk_inc;
                        ram_rd_addr   = walk_inc[IDX_W-1:0];
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    last_to_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM write: a start loads both values; the walk writes back the
    // counted-down or reloaded remaining value.
    always_comb
    begin
        wb_entry.reload_ms    = rd_entry.reload_ms;
        wb_entry.remaining_ms = cur_fire ? rd_entry.reload_ms
                                         : (rd_entry.remaining_ms - elapsed_reg);
        if (start_ok)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = IDX_W'(cmd.timer_index);
            ram_wr_data = {cmd.load_ms, cmd.load_ms};
        end
        else
        begin
            ram_wr_en   = advance && cur_act;
            ram_wr_addr = walk_idx_reg[IDX_W-1:0];
            ram_wr_data = wb_entry;
        end
    end

    stbu_ram #(
        .WIDTH ($bits(timer_entry_t)),
        .DEPTH (MAX_TIMERS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            walk_idx_reg      <= '0;
            timers_in_use_reg <= '0;
            repeat_mask_reg   <= '0;
            notify_mask_reg   <= NOTIFY_MASK_RESET;
            active_reg        <= '0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_idx_reg <= walk_idx_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TIMERS_IN_USE: timers_in_use_reg <= cfg_data[COUNT_W-1:0];
                    REG_REPEAT_MASK:   repeat_mask_reg   <= cfg_data[MASK_W-1:0];
                    REG_NOTIFY_MASK:   notify_mask_reg   <= cfg_data[MASK_W-1:0];
                    default:           ;
                endcase
            end

            if (start_ok)
            begin
                active_reg[IDX_W'(cmd.timer_index)] <= 1'b1;
            end
            if (stop_ok)
            begin
                active_reg[IDX_W'(cmd.timer_index)] <= 1'b0;
            end
            if (advance && cur_fire)
            begin
                active_reg[walk_idx_reg[IDX_W-1:0]] <= cur_repeat;
            end
            // Shrinking the count retires every timer at or above it.
            for (int t = 0; t < MAX_TIMERS; t++)
            begin
                if (cfg_count_wr && (t >= 32'(new_cnt)))
                begin
                    active_reg[t] <= 1'b0;
                end
            end

            if (advance && cur_notify)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (last_to_out)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_to_out || last_to_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            elapsed_reg <= cmd.elapsed_ms;
        end
        if (advance && cur_notify)
        begin
            pend_idx_reg <= 3'(walk_idx_reg);
        end
        if (pend_to_out || last_to_out)
        begin
            out_idx_reg  <= pend_idx_reg;
            out_last_reg <= last_to_out;
        end
    end

    assign evt.valid         = out_valid_reg;
    assign evt.expired_timer = out_idx_reg;
    assign evt.last          = out_last_reg;

    // The bank takes a new item only once the final event of a tick has left
    // the pending register.
    `STBU_ASSERT_IMPL(a_idle_no_pending, clk, rst_n, state_reg == ST_IDLE, !pend_valid_reg, "pending event left behind in idle")
    // An event without the last flag is always followed by a pending one.
    `STBU_ASSERT_IMPL(a_not_last_has_successor, clk, rst_n, out_valid_reg && !out_last_reg, pend_valid_reg, "non-final event has no successor")
    // No timer at or above the count in use is ever active.
    `STBU_ASSERT_IMPL(a_unused_inactive, clk, rst_n, 1'b1, (active_reg >> n_eff) == '0, "timer outside the count in use is active")
    // A tick item always starts a walk or goes straight to the flush step.
    `STBU_ASSERT_NEXT(a_tick_starts_walk, clk, rst_n, tick_go, state_reg == ST_EVAL || state_reg == ST_FLUSH, "tick item did not start a walk")

endmodule

[src/stbu_ram.sv]
// ----------------------------------------------------------------------------
// Generic timer bank RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module stbu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Timer bank testbench
// Sends start, stop and tick items to the timer bank in random bursts and
// gaps while the event side stalls. A model of the bank in the testbench
// predicts every expiry event, and each event is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stbu_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int NUM_TIMERS   = 8;
    localparam int CYCLE_LIMIT  = 400000;
    // The drain gives ample settling time for a tick walk that finishes on
    // timers that raise no event.
    localparam int DRAIN_CYCLES = 2 * NUM_TIMERS + 4;
    localparam int PHASE_ITEMS  = 46;
    localparam int NUM_PHASES   = 8;
    // Command code 3 has no meaning. The bank must swallow it.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // A mask entry above 255 means that a fresh random mask is drawn.
    localparam int unsigned PICK_RANDOM = 256;
    localparam int unsigned PHASE_COUNT [NUM_PHASES] = '{8, 8, 5, 1, 15, 6, 8, 7};
    localparam int unsigned PHASE_REPEAT[NUM_PHASES] =
        '{255, 0, 'h5A, 255, PICK_RANDOM, PICK_RANDOM, PICK_RANDOM, 'h0F};
    localparam int unsigned PHASE_NOTIFY[NUM_PHASES] =
        '{255, 255, 'hC3, 'h01, PICK_RANDOM, 255, PICK_RANDOM, 'h7F};

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIDX_W-1:0] timer_index;
        logic [MS_W-1:0]   load_ms;
        logic [MS_W-1:0]   elapsed_ms;
    } cmd_item_t;

    typedef struct packed {
        logic [TIDX_W-1:0] expired_timer;
        logic              last;
    } expiry_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_TIMERS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    stbu_cmd_if cmd_ch ();
    stbu_evt_if evt_ch ();

    software_timer_bank_unit #(
        .MAX_TIMERS(NUM_TIMERS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_ch),
        .evt      (evt_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Items that wait for the driver, and the expiry events that the bank
    // still owes, oldest first.
    cmd_item_t pending_items[$];
    expiry_t   expected_expiries[$];

    // The testbench's own copy of the bank state and its registers.
    logic              shadow_active   [NUM_TIMERS];
    logic [MS_W-1:0]   shadow_remaining[NUM_TIMERS];
    logic [MS_W-1:0]   shadow_reload   [NUM_TIMERS];
    logic [COUNT_W-1:0] shadow_count;
    logic [MASK_W-1:0] shadow_repeat;
    logic [MASK_W-1:0] shadow_notify;

    int   items_accepted   = 0;
    int   ticks_accepted   = 0;
    int   events_checked   = 0;
    int   settings_applied = 0;
    int   error_count      = 0;
    int   cycle_count      = 0;
    int   gap_left         = 0;
    int   burst_left       = 0;
    int   stall_left       = 0;
    int   stall_mode       = 0;
    logic cmd_fire         = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A count register above the bank size behaves as the full bank.
    function automatic int timers_live();
        return (int'(shadow_count) > NUM_TIMERS) ? NUM_TIMERS : int'(shadow_count);
    endfunction

    // Applies one accepted item to the model. A tick appends its expiry
    // events in ascending timer order, and the final one of them carries last.
    function automatic void predict_timer_bank(cmd_item_t it);
        int live;
        int first;
        expiry_t ev;
        live  = timers_live();
        first = expected_expiries.size();
        case (it.command)
            CMD_START:
            begin
                if (int'(it.timer_index) < live)
                begin
                    shadow_active[it.timer_index]    = 1'b1;
                    shadow_remaining[it.timer_index] = it.load_ms;
                    shadow_reload[it.timer_index]    = it.load_ms;
                end
            end
            CMD_STOP:
            begin
                if (int'(it.timer_index) < live)
                    shadow_active[it.timer_index] = 1'b0;
            end
            CMD_TICK:
            begin
                for (int i = 0; i < live; i++)
                begin
                    if (shadow_active[i])
                    begin
                        if (shadow_remaining[i] > it.elapsed_ms)
                            shadow_remaining[i] = shadow_remaining[i] - it.elapsed_ms;
                        else
                        begin
                            // The timer fires. It reloads, and only a repeating
                            // timer stays armed.
                            shadow_remaining[i] = shadow_reload[i];
                            shadow_active[i]    = shadow_repeat[i];
                            if (shadow_notify[i])
                            begin
                                ev.expired_timer = TIDX_W'(i);
                                ev.last          = 1'b0;
                                expected_expiries.push_back(ev);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        if (expected_expiries.size() > first)
            expected_expiries[expected_expiries.size() - 1].last = 1'b1;
    endfunction

    function automatic void queue_item(logic [CMD_W-1:0] command, int unsigned idx,
                                       int unsigned duration, int unsigned elapsed);
        cmd_item_t it;
        it.command     = command;
        it.timer_index = TIDX_W'(idx);
        it.load_ms     = MS_W'(duration);
        it.elapsed_ms  = MS_W'(elapsed);
        pending_items.push_back(it);
    endfunction

    // Mostly short times so that timers fire often, now and then any value,
    // so that every bit of the field is exercised.
    function automatic int unsigned pick_ms(int unsigned short_max);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, short_max);
        else if (roll < 90)
            return $urandom_range(0, 1000);
        else if (roll < 97)
            return $urandom_range(0, 65535);
        return (roll % 2 == 0) ? 0 : 65535;
    endfunction

    // Waits until every item has been taken and every expected event has
    // arrived, then gives the bank time to finish its walk.
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_items.size() != 0 || cmd_ch.valid);
        while (expected_expiries.size() != 0)
        begin
            @(negedge clk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        // The bank is idle, so the model can follow the write right away.
        case (idx)
            REG_TIMERS_IN_USE:
            begin
                shadow_count = COUNT_W'(value);
                // Timers that drop out of use come back cleared.
                for (int i = timers_live(); i < NUM_TIMERS; i++)
                begin
                    shadow_active[i]    = 1'b0;
                    shadow_remaining[i] = '0;
                    shadow_reload[i]    = '0;
                end
            end
            REG_REPEAT_MASK: shadow_repeat = MASK_W'(value);
            REG_NOTIFY_MASK: shadow_notify = MASK_W'(value);
            default: ;
        endcase
    endtask

    // Writes all three registers once the bank is idle. It also moves the
    // event side on to its next stall pattern.
    task automatic apply_setting(int unsigned count, int unsigned repeat_bits,
                                 int unsigned notify_bits);
        wait_idle();
        write_register(REG_TIMERS_IN_USE, count);
        write_register(REG_REPEAT_MASK, repeat_bits);
        write_register(REG_NOTIFY_MASK, notify_bits);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
        stall_mode = settings_applied % 4;
        @(posedge clk);
    endtask

    // Mostly starts and ticks on timers in use, with stops mixed in. The rest
    // is noise: the unused command and starts or stops of any index. Only
    // items that can change the bank count toward the target.
    task automatic queue_random_traffic(int target);
        int counted;
        int roll;
        int live;
        int unsigned idx;
        logic [CMD_W-1:0] command;
        counted = 0;
        live    = timers_live();
        while (counted < target)
        begin
            roll = $urandom_range(0, 99);
            idx  = (live > 0) ? $urandom_range(0, live - 1) : $urandom_range(0, 7);
            if (roll < 40)
                command = CMD_START;
            else if (roll < 75)
                command = CMD_TICK;
            else if (roll < 90)
                command = CMD_STOP;
            else if (roll < 95)
                command = CMD_UNUSED;
            else
            begin
                command = (roll % 2 == 0) ? CMD_START : CMD_STOP;
                idx     = $urandom_range(0, 7);
            end
            queue_item(command, idx, pick_ms(40), pick_ms(15));
            if (command == CMD_TICK || (command != CMD_UNUSED && idx < live))
                counted++;
        end
    endtask

    // Command driver. An item stays on the channel until it is taken. Items
    // go out in bursts of random length, and the gap after a burst is often
    // zero, so that the bank also sees long runs with no idle cycles.
    always @(negedge clk)
    begin
        cmd_item_t next_item;
        logic      send;
        if (rst_n && !(cmd_ch.valid && !cmd_fire))
        begin
            send = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                send      = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    if ($urandom_range(0, 2) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 20 : 4);
                end
            end
            cmd_ch.valid <= send;
            if (send)
            begin
                cmd_ch.command     <= next_item.command;
                cmd_ch.timer_index <= next_item.timer_index;
                cmd_ch.load_ms     <= next_item.load_ms;
                cmd_ch.elapsed_ms  <= next_item.elapsed_ms;
            end
        end
    end

    // Event sink. Each setting brings its own stall pattern: none, short
    // frequent stalls, rare long stalls, or a fixed beat.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            evt_ch.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            evt_ch.ready <= 1'b1;
            case (stall_mode)
                1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(4, 12);
                3: stall_left = (cycle_count % 3 == 0) ? 1 : 0;
                default: ;
            endcase
        end
    end

    // Monitor. It checks events against the oldest expectation and feeds each
    // accepted command item to the model. Both channels are sampled at the
    // rising edge, before the bank updates its outputs.
    always @(posedge clk)
    begin
        expiry_t   oldest;
        cmd_item_t taken;
        cmd_fire <= rst_n && cmd_ch.valid && cmd_ch.ready;
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            if (expected_expiries.size() == 0)
            begin
                $error("expiry event for timer %0d with none expected", evt_ch.expired_timer);
                error_count++;
            end
            else
            begin
                oldest = expected_expiries.pop_front();
                events_checked++;
                if (evt_ch.expired_timer !== oldest.expired_timer)
                begin
                    $error("expired_timer: expected %0d, got %0d",
                           oldest.expired_timer, evt_ch.expired_timer);
                    error_count++;
                end
                if (evt_ch.last !== oldest.last)
                begin
                    $error("last: expected %0d, got %0d", oldest.last, evt_ch.last);
                    error_count++;
                end
            end
        end
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            taken.command     = cmd_ch.command;
            taken.timer_index = cmd_ch.timer_index;
            taken.load_ms     = cmd_ch.load_ms;
            taken.elapsed_ms  = cmd_ch.elapsed_ms;
            predict_timer_bank(taken);
            items_accepted++;
            if (taken.command == CMD_TICK)
                ticks_accepted++;
        end
    end

    // The run fails if it has not finished within the cycle limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cycle limit reached, %0d items waiting, %0d events outstanding",
                 pending_items.size(), expected_expiries.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned repeat_bits;
        int unsigned notify_bits;

        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_TICK;
        cmd_ch.timer_index = '0;
        cmd_ch.load_ms     = '0;
        cmd_ch.elapsed_ms  = '0;
        evt_ch.ready       = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            shadow_active[i]    = 1'b0;
            shadow_remaining[i] = '0;
            shadow_reload[i]    = '0;
        end
        shadow_count  = '0;
        shadow_repeat = '0;
        shadow_notify = NOTIFY_MASK_RESET;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With no timers allocated after reset, every item must be ignored.
        queue_item(CMD_START, 0, 5, $urandom);
        queue_item(CMD_TICK, $urandom, $urandom, 10);
        queue_item(CMD_STOP, 0, $urandom, $urandom);

        // Full bank with alternate timers repeating. The durations cover zero,
        // the maximum and a timer that fires on a zero-length tick. Then come
        // a stop, the unused command and a stop of a timer that is armed.
        apply_setting(8, 'hAA, 255);
        queue_item(CMD_START, 0, 0, $urandom);
        queue_item(CMD_START, 1, 65535, $urandom);
        queue_item(CMD_START, 2, 1, $urandom);
        queue_item(CMD_START, 3, 100, $urandom);
        queue_item(CMD_START, 7, 3, $urandom);
        queue_item(CMD_TICK, $urandom, $urandom, 0);
        queue_item(CMD_TICK, $urandom, $urandom, 65535);
        queue_item(CMD_STOP, 3, $urandom, $urandom);
        queue_item(CMD_UNUSED, $urandom, $urandom, $urandom);
        queue_item(CMD_START, 5, 2, $urandom);
        queue_item(CMD_TICK, $urandom, $urandom, 1);
        queue_item(CMD_TICK, $urandom, $urandom, 2);
        queue_item(CMD_STOP, 7, $urandom, $urandom);
        queue_item(CMD_TICK, $urandom, $urandom, 65535);

        // Shrinking to three timers clears the rest, and items to them are
        // ignored. Zero-length repeating timers fire on every tick, and only
        // the ones with a notify bit raise an event.
        apply_setting(3, 255, 'h05);
        queue_item(CMD_START, 4, 1, $urandom);
        queue_item(CMD_STOP, 6, $urandom, $urandom);
        queue_item(CMD_START, 2, 0, $urandom);
        queue_item(CMD_START, 1, 0, $urandom);
        queue_item(CMD_TICK, $urandom, $urandom, 0);
        queue_item(CMD_TICK, $urandom, $urandom, 0);

        // A count above the bank size acts as the full bank.
        apply_setting(15, 0, 'h80);
        queue_item(CMD_START, 7, 0, $urandom);
        queue_item(CMD_TICK, $urandom, $urandom, 0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            repeat_bits = (PHASE_REPEAT[p] >= PICK_RANDOM) ? $urandom_range(0, 255)
                                                           : PHASE_REPEAT[p];
            notify_bits = (PHASE_NOTIFY[p] >= PICK_RANDOM) ? $urandom_range(0, 255)
                                                           : PHASE_NOTIFY[p];
            apply_setting(PHASE_COUNT[p], repeat_bits, notify_bits);
            queue_random_traffic(PHASE_ITEMS);
        end

        wait_idle();
        $display("%0d command items taken (%0d ticks) across %0d register settings",
                 items_accepted, ticks_accepted, settings_applied);
        $display("%0d expiry events checked, %0d errors", events_checked, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/stbu_pkg.sv
src/stbu_if.sv
src/stbu_ram.sv
src/software_timer_bank_unit.sv
tb/testbench.sv
